// File: rtl/tgi_pkg.sv
// ----------------------------------------------------------------------------
// tgi_pkg : shared constants and types for the trilinear grid interpolator
// Grid geometry, fixed-point format and pipeline record types.
// ----------------------------------------------------------------------------
`default_nettype none
package tgi_pkg;
    localparam int XBits = 6;
    localparam int YBits = 6;
    localparam int TBits = 6;
    localparam int XPoints = 1 << XBits;
    localparam int YPoints = 1 << YBits;
    localparam int TPoints = 1 << TBits;
    localparam int FracBits = 8;
    localparam int ValBits = 16;
    // each bank holds one parity corner: (x,y,t) halved
    localparam int BankAddrBits = XBits + YBits + TBits - 3;
    localparam int BankDepth = 1 << BankAddrBits;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_QUERY = 1'b1
    } func_t;

    typedef logic [FracBits-1:0] frac_t;
    typedef logic [ValBits-1:0]  val_t;

    // query state carried alongside the memory read
    typedef struct packed {
        logic  valid;
        logic  in_range;
        logic  [2:0] par;      // parity of lower x, y, t
        frac_t dx;
        frac_t dy;
        frac_t dt;
    } qry_t;

    // one lerp: (a*(2^F-d) + b*d) >> F
    function automatic val_t lerp(input val_t a, input val_t b, input frac_t d);
        logic [ValBits+FracBits:0] s;
        s = {{(FracBits+1){1'b0}}, a} * ({1'b1, {FracBits{1'b0}}} - {1'b0, d})
          + {{(FracBits+1){1'b0}}, b} * {1'b0, d};
        return s[FracBits +: ValBits];
    endfunction
endpackage
`default_nettype wire

// File: rtl/tgi_if.sv
// ----------------------------------------------------------------------------
// tgi_in_if / tgi_out_if : valid-ready channels of the interpolator
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
`default_nettype none
interface tgi_in_if;
    logic valid;
    logic ready;
    logic func;
    logic signed [14:0] x_pos;
    logic signed [14:0] y_pos;
    logic signed [15:0] tau_pos;
    logic [5:0] entry_x;
    logic [5:0] entry_y;
    logic [5:0] entry_tau;
    logic [15:0] entry_value;
    modport source (output valid, func, x_pos, y_pos, tau_pos, entry_x, entry_y,
                    entry_tau, entry_value, input ready);
    modport sink (input valid, func, x_pos, y_pos, tau_pos, entry_x, entry_y,
                  entry_tau, entry_value, output ready);
endinterface

interface tgi_out_if;
    logic valid;
    logic ready;
    logic [15:0] result_value;
    logic in_range;
    modport source (output valid, result_value, in_range, input ready);
    modport sink (input valid, result_value, in_range, output ready);
endinterface
`default_nettype wire

// File: rtl/tgi_ram.sv
// ----------------------------------------------------------------------------
// tgi_ram : generic single-port-write, single-read RAM
// Registered read; read enable holds the data.
// ----------------------------------------------------------------------------
`default_nettype none
module tgi_ram #(
    parameter int Width = 16,
    parameter int Depth = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// File: rtl/tgi_addr.sv
// ----------------------------------------------------------------------------
// tgi_addr : cell lookup for a query
// Floors positions, checks range, forms the eight bank read addresses.
// ----------------------------------------------------------------------------
`default_nettype none
module tgi_addr (
    input  wire logic signed [14:0] x_pos,
    input  wire logic signed [14:0] y_pos,
    input  wire logic signed [15:0] tau_pos,
    output logic                    in_range,
    output logic [2:0]              par,
    output logic [tgi_pkg::BankAddrBits-1:0] raddr [8]
);
    logic signed [7:0] xf, yf, tf;     // floor of position
    logic signed [8:0] xi, yi, ti;
    logic [tgi_pkg::XBits-1:0] x0;
    logic [tgi_pkg::YBits-1:0] y0;
    logic [tgi_pkg::TBits-1:0] t0;
    logic [tgi_pkg::XBits-1:0] xc;
    logic [tgi_pkg::YBits-1:0] yc;
    logic [tgi_pkg::TBits-1:0] tc;

    always_comb
    begin
        xf = 8'(x_pos >>> tgi_pkg::FracBits);
        yf = 8'(y_pos >>> tgi_pkg::FracBits);
        tf = 8'(tau_pos >>> tgi_pkg::FracBits);
        xi = 9'(xf) + 9'(tgi_pkg::XPoints / 2);
        yi = 9'(yf) + 9'(tgi_pkg::YPoints / 2);
        ti = 9'(tf);
        in_range = (xi >= 0) && (xi <= 9'(tgi_pkg::XPoints - 2))
                && (yi >= 0) && (yi <= 9'(tgi_pkg::YPoints - 2))
                && (ti >= 0) && (ti <= 9'(tgi_pkg::TPoints - 2));
        x0 = xi[tgi_pkg::XBits-1:0];
        y0 = yi[tgi_pkg::YBits-1:0];
        t0 = ti[tgi_pkg::TBits-1:0];
        par = {x0[0], y0[0], t0[0]};
        // bank b = {xp,yp,tp} parity of the corner; index is coordinate >> 1
        for (int b = 0; b < 8; b++)
        begin
            // corner coordinate with parity bit of bank: lower if equal parity
            xc = (b[2] == x0[0]) ? x0 : x0 + 1'b1;
            yc = (b[1] == y0[0]) ? y0 : y0 + 1'b1;
            tc = (b[0] == t0[0]) ? t0 : t0 + 1'b1;
            raddr[b] = {xc[tgi_pkg::XBits-1:1], yc[tgi_pkg::YBits-1:1],
                        tc[tgi_pkg::TBits-1:1]};
        end
    end
endmodule
`default_nettype wire

// File: rtl/trilinear_grid_interpolator_top.sv
// ----------------------------------------------------------------------------
// trilinear_grid_interpolator_top : banked sample table with lerp pipeline
// Stores a 64x64x64 grid of 16-bit samples and answers trilinear queries.
// ----------------------------------------------------------------------------
// One beat per cycle in both directions while the output is not stalled. A write
// beat (func=0) stores one sample and gives no result; a query beat (func=1)
// gives exactly one result: the bank read happens at its accepting edge with
// the addresses formed combinationally, then one stage each for the x lerps,
// the y lerps and the t lerp into the output register. The table is split by
// index parity into eight banks of 32768 words, so the eight corners of any
// cell come from distinct banks and are read together. Queries outside the
// grid return zero with in_range low. A read of a sample never written returns
// whatever the RAM holds. Writes go straight into the banks; a query accepted
// after a write sees it, since the read happens after the write's edge. The
// whole pipeline advances only when its output register is free or being
// drained.
// ----------------------------------------------------------------------------
`default_nettype none
module trilinear_grid_interpolator_top (
    input wire logic clk,
    input wire logic rst_n,
    tgi_in_if.sink   in_ch,
    tgi_out_if.source out_ch
);
    logic adv;                              // pipeline advances
    logic acc;
    logic in_range_c;
    logic [2:0] par_c;
    logic [tgi_pkg::BankAddrBits-1:0] raddr [8];
    logic [tgi_pkg::BankAddrBits-1:0] waddr;
    logic [2:0] wbank;
    tgi_pkg::val_t rdata [8];

    tgi_pkg::qry_t s1_reg, s1_next, s2_reg, s3_reg;
    tgi_pkg::val_t cx_reg [4];              // x lerps: index {y,t}
    tgi_pkg::val_t cy_reg [2];              // y lerps: index t
    tgi_pkg::val_t res_reg;
    logic ovalid_reg, orange_reg;

    assign adv = !ovalid_reg || out_ch.ready;
    assign in_ch.ready = adv;
    assign acc = in_ch.valid && adv;

    tgi_addr u_addr (
        .x_pos(in_ch.x_pos), .y_pos(in_ch.y_pos), .tau_pos(in_ch.tau_pos),
        .in_range(in_range_c), .par(par_c), .raddr(raddr)
    );

    assign wbank = {in_ch.entry_x[0], in_ch.entry_y[0], in_ch.entry_tau[0]};
    assign waddr = {in_ch.entry_x[5:1], in_ch.entry_y[5:1], in_ch.entry_tau[5:1]};

    for (genvar b = 0; b < 8; b++)
    begin : g_bank
        tgi_ram #(.Width(tgi_pkg::ValBits), .Depth(tgi_pkg::BankDepth)) u_ram (
            .clk(clk),
            .we(acc && (in_ch.func == tgi_pkg::FUNC_WRITE) && (wbank == 3'(b))),
            .waddr(waddr), .wdata(in_ch.entry_value),
            .re(adv), .raddr(raddr[b]), .rdata(rdata[b])
        );
    end

    always_comb
    begin
        s1_next.valid = acc && (in_ch.func == tgi_pkg::FUNC_QUERY);
        s1_next.in_range = in_range_c;
        s1_next.par = par_c;
        s1_next.dx = in_ch.x_pos[tgi_pkg::FracBits-1:0];
        s1_next.dy = in_ch.y_pos[tgi_pkg::FracBits-1:0];
        s1_next.dt = in_ch.tau_pos[tgi_pkg::FracBits-1:0];
    end

    // corner sample: lower/upper along each axis mapped through parity
    function automatic tgi_pkg::val_t corner(input tgi_pkg::val_t d [8],
                                             input logic [2:0] p,
                                             input logic [2:0] c);
        return d[p ^ c];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
            ovalid_reg <= s3_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
            begin
                cx_reg[k] <= tgi_pkg::lerp(
                    corner(rdata, s1_reg.par, {1'b0, 2'(k)}),
                    corner(rdata, s1_reg.par, {1'b1, 2'(k)}), s1_reg.dx);
            end
            cy_reg[0] <= tgi_pkg::lerp(cx_reg[0], cx_reg[2], s2_reg.dy);
            cy_reg[1] <= tgi_pkg::lerp(cx_reg[1], cx_reg[3], s2_reg.dy);
            res_reg <= s3_reg.in_range ? tgi_pkg::lerp(cy_reg[0], cy_reg[1], s3_reg.dt)
                                       : '0;
            orange_reg <= s3_reg.in_range;
        end
    end

    assign out_ch.valid = ovalid_reg;
    assign out_ch.result_value = res_reg;
    assign out_ch.in_range = orange_reg;

    // a stalled result holds its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.result_value))
        else $error("result changed while stalled");
    // out-of-range result is zero
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.in_range |-> out_ch.result_value == '0)
        else $error("out of range result not zero");
    // an accepted query beat occupies the first stage
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready && in_ch.func == tgi_pkg::FUNC_QUERY |=> s1_reg.valid)
        else $error("query lost at entry");
endmodule
`default_nettype wire

// File: dv/tb_trilinear_grid_interpolator_top.sv
// ----------------------------------------------------------------------------
// tb_trilinear_grid_interpolator_top : self-checking bench for the interpolator
// Loads part of the sample grid, then streams query and write beats with random
// idling on both channels and checks every result against a local predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_trilinear_grid_interpolator_top;

    typedef struct packed {
        tgi_pkg::func_t func;
        logic [14:0] x_pos;
        logic [14:0] y_pos;
        logic [15:0] tau_pos;
        logic [5:0]  entry_x;
        logic [5:0]  entry_y;
        logic [5:0]  entry_tau;
        logic [15:0] entry_value;
    } beat_t;

    typedef struct packed {
        logic [15:0] value;
        logic        in_range;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tgi_in_if  in_ch();
    tgi_out_if out_ch();

    trilinear_grid_interpolator_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always #2 clk = ~clk;

    // local copy of the grid; the bench only queries cells it has loaded
    logic [15:0] grid [0:tgi_pkg::XPoints*tgi_pkg::YPoints*tgi_pkg::TPoints-1];

    beat_t   pending_beats[$];
    answer_t expected_answers[$];
    int      errors = 0;
    int      queries_sent = 0;
    int      writes_sent = 0;
    int      in_range_seen = 0;
    int      answers_seen = 0;
    bit      stimulus_done = 1'b0;
    bit      calm = 1'b0;   // long stretch without idling

    function automatic int grid_index(int ix, int iy, int it);
        return (ix * tgi_pkg::YPoints + iy) * tgi_pkg::TPoints + it;
    endfunction

    function automatic logic [15:0] blend(logic [15:0] a, logic [15:0] b, logic [7:0] d);
        logic [31:0] s;
        s = 32'(a) * (32'd256 - 32'(d)) + 32'(b) * 32'(d);
        return s[23:8];
    endfunction

    function automatic int lower_cell(int p);
        return p >>> tgi_pkg::FracBits;   // arithmetic shift = floor
    endfunction

    function automatic bit cell_in_range(int xp, int yp, int tp);
        int xi, yi, ti;
        xi = lower_cell(xp) + tgi_pkg::XPoints / 2;
        yi = lower_cell(yp) + tgi_pkg::YPoints / 2;
        ti = lower_cell(tp);
        return !(xi < 0 || xi > tgi_pkg::XPoints - 2 || yi < 0 ||
                 yi > tgi_pkg::YPoints - 2 || ti < 0 || ti > tgi_pkg::TPoints - 2);
    endfunction

    // predicts the answer to one query against the local grid
    function automatic answer_t interpolate(beat_t b);
        answer_t r;
        int xi, yi, ti;
        logic [7:0] dx, dy, dt;
        logic [15:0] c00, c01, c10, c11, c0, c1;
        xi = lower_cell(int'($signed(b.x_pos))) + tgi_pkg::XPoints / 2;
        yi = lower_cell(int'($signed(b.y_pos))) + tgi_pkg::YPoints / 2;
        ti = lower_cell(int'($signed(b.tau_pos)));
        r = '0;
        if (xi < 0 || xi > tgi_pkg::XPoints - 2 || yi < 0 || yi > tgi_pkg::YPoints - 2 ||
            ti < 0 || ti > tgi_pkg::TPoints - 2)
            return r;
        dx = b.x_pos[7:0];
        dy = b.y_pos[7:0];
        dt = b.tau_pos[7:0];
        c00 = blend(grid[grid_index(xi, yi, ti)], grid[grid_index(xi+1, yi, ti)], dx);
        c01 = blend(grid[grid_index(xi, yi, ti+1)], grid[grid_index(xi+1, yi, ti+1)], dx);
        c10 = blend(grid[grid_index(xi, yi+1, ti)], grid[grid_index(xi+1, yi+1, ti)], dx);
        c11 = blend(grid[grid_index(xi, yi+1, ti+1)],
                    grid[grid_index(xi+1, yi+1, ti+1)], dx);
        c0 = blend(c00, c10, dy);
        c1 = blend(c01, c11, dy);
        r.value = blend(c0, c1, dt);
        r.in_range = 1'b1;
        return r;
    endfunction

    function automatic beat_t write_beat(int ix, int iy, int it, logic [15:0] v);
        beat_t b;
        b = '0;
        b.func = tgi_pkg::FUNC_WRITE;
        b.entry_x = 6'(ix);
        b.entry_y = 6'(iy);
        b.entry_tau = 6'(it);
        b.entry_value = v;
        // query fields carry junk on writes
        b.x_pos = 15'($urandom);
        b.y_pos = 15'($urandom);
        b.tau_pos = 16'($urandom);
        return b;
    endfunction

    function automatic beat_t query_beat(int xp, int yp, int tp);
        beat_t b;
        b = '0;
        b.func = tgi_pkg::FUNC_QUERY;
        b.x_pos = 15'(xp);
        b.y_pos = 15'(yp);
        b.tau_pos = 16'(tp);
        b.entry_x = 6'($urandom);
        b.entry_y = 6'($urandom);
        b.entry_tau = 6'($urandom);
        b.entry_value = 16'($urandom);
        return b;
    endfunction

    // random query: mostly inside the loaded block (x/y index 28..35, tau 0..7),
    // otherwise anywhere in the field ranges but forced out of the grid
    function automatic beat_t random_query();
        int xp, yp, tp;
        if ($urandom_range(0, 9) < 8)
        begin
            xp = int'($urandom_range(0, 7 * 256 - 1)) - 4 * 256;
            yp = int'($urandom_range(0, 7 * 256 - 1)) - 4 * 256;
            tp = int'($urandom_range(0, 7 * 256 - 1));
        end
        else
        begin
            xp = int'($urandom_range(0, 32767)) - 16384;
            yp = int'($urandom_range(0, 32767)) - 16384;
            tp = int'($urandom_range(0, 65535)) - 32768;
            if (cell_in_range(xp, yp, tp))
                tp = -1 - int'($urandom_range(0, 32767));
        end
        return query_beat(xp, yp, tp);
    endfunction

    // stimulus: block and corner loads, directed corners, then mixed traffic
    initial
    begin
        int n;
        for (int ix = 28; ix < 36; ix++)
            for (int iy = 28; iy < 36; iy++)
                for (int it = 0; it < 8; it++)
                    pending_beats.push_back(write_beat(ix, iy, it, 16'($urandom)));
        for (int ix = 0; ix < 2; ix++)
            for (int iy = 0; iy < 2; iy++)
                for (int it = 0; it < 2; it++)
                begin
                    pending_beats.push_back(write_beat(ix, iy, it, 16'($urandom)));
                    pending_beats.push_back(write_beat(62 + ix, 62 + iy, 62 + it,
                                                       16'($urandom)));
                end
        // extreme samples around the low corner and the high corner
        pending_beats.push_back(write_beat(0, 0, 0, 16'hFFFF));
        pending_beats.push_back(write_beat(1, 1, 1, 16'h0000));
        pending_beats.push_back(write_beat(63, 63, 63, 16'hFFFF));
        pending_beats.push_back(write_beat(62, 62, 62, 16'hFFFF));
        pending_beats.push_back(query_beat(-32 * 256, -32 * 256, 0));        // lowest cell
        pending_beats.push_back(query_beat(-32 * 256 + 255, -32 * 256 + 255, 255));
        pending_beats.push_back(query_beat(31 * 256 - 1, 31 * 256 - 1, 63 * 256 - 1));
        pending_beats.push_back(query_beat(31 * 256, 0, 0));                 // x upper edge
        pending_beats.push_back(query_beat(0, 31 * 256, 0));                 // y upper edge
        pending_beats.push_back(query_beat(0, 0, 63 * 256));                 // tau upper edge
        pending_beats.push_back(query_beat(0, 0, -1));                       // negative tau
        pending_beats.push_back(query_beat(-32 * 256 - 1, 0, 0));            // below x
        pending_beats.push_back(query_beat(0, -32 * 256 - 1, 0));            // below y
        pending_beats.push_back(query_beat(-16384, -16384, -32768));
        pending_beats.push_back(query_beat(16383, 16383, 32767));
        pending_beats.push_back(query_beat(0, 0, 0));
        pending_beats.push_back(query_beat(128, -128, 256 + 128));
        // write beyond the grid is impossible at 6 bits; overwrite then query
        pending_beats.push_back(write_beat(32, 32, 0, 16'h1234));
        pending_beats.push_back(query_beat(0, 0, 0));
        n = 0;
        while (n < 1200)
        begin
            if ($urandom_range(0, 3) == 0)
                pending_beats.push_back(write_beat($urandom_range(28, 35),
                    $urandom_range(28, 35), $urandom_range(0, 7), 16'($urandom)));
            else
                pending_beats.push_back(random_query());
            n++;
        end
        stimulus_done = 1'b1;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver: predictor updated at the moment a beat is accepted
    always @(posedge clk)
    begin
        beat_t b;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            {in_ch.func, in_ch.x_pos, in_ch.y_pos, in_ch.tau_pos, in_ch.entry_x,
             in_ch.entry_y, in_ch.entry_tau, in_ch.entry_value} <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                b = {in_ch.func, in_ch.x_pos, in_ch.y_pos, in_ch.tau_pos, in_ch.entry_x,
                     in_ch.entry_y, in_ch.entry_tau, in_ch.entry_value};
                if (b.func == tgi_pkg::FUNC_WRITE)
                begin
                    grid[grid_index(b.entry_x, b.entry_y, b.entry_tau)] = b.entry_value;
                    writes_sent++;
                end
                else
                begin
                    expected_answers.push_back(interpolate(b));
                    queries_sent++;
                end
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_beats.size() > 0 && (calm || $urandom_range(0, 99) >= 29))
                begin
                    b = pending_beats.pop_front();
                    in_ch.valid <= 1'b1;
                    {in_ch.func, in_ch.x_pos, in_ch.y_pos, in_ch.tau_pos, in_ch.entry_x,
                     in_ch.entry_y, in_ch.entry_tau, in_ch.entry_value} <= b;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor and sink-side back-pressure
    always @(posedge clk)
    begin
        answer_t want;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            out_ch.ready <= calm || ($urandom_range(0, 99) >= 29);
            if (out_ch.valid && out_ch.ready)
            begin
                answers_seen++;
                if (expected_answers.size() == 0)
                begin
                    $display("%0t: unexpected result value=%h in_range=%b", $time,
                             out_ch.result_value, out_ch.in_range);
                    errors++;
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (out_ch.in_range)
                        in_range_seen++;
                    if (out_ch.result_value !== want.value)
                    begin
                        $display("%0t: result_value expected %h actual %h", $time,
                                 want.value, out_ch.result_value);
                        errors++;
                    end
                    if (out_ch.in_range !== want.in_range)
                    begin
                        $display("%0t: in_range expected %b actual %b", $time,
                                 want.in_range, out_ch.in_range);
                        errors++;
                    end
                end
            end
        end
    end

    // calm stretch partway through the random traffic
    always @(posedge clk)
        calm <= (writes_sent + queries_sent > 800) &&
                (writes_sent + queries_sent < 1200);

    initial
    begin
        while (!(stimulus_done && rst_n))
            @(posedge clk);
        while (pending_beats.size() != 0 || in_ch.valid)
            @(posedge clk);
        while (expected_answers.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("Covered %0d writes and %0d queries, %0d results (%0d in range).",
                 writes_sent, queries_sent, answers_seen, in_range_seen);
        if (errors == 0 && expected_answers.size() == 0)
            $display("PASS trilinear_grid_interpolator_top");
        else
            $display("FAIL trilinear_grid_interpolator_top");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("FAIL trilinear_grid_interpolator_top");
        $finish;
    end
endmodule
